### design/gb3_pkg.sv
// Shared widths, register indexes and bundle types of the 3x3 Gaussian blur.
package gb3_pkg;

   localparam int PIXEL_W           = 8;
   localparam int WIDTH_REG_W       = 11;
   localparam int HEIGHT_REG_W      = 13;
   localparam int CSR_DATA_W        = 13;
   localparam int CSR_INDEX_W       = 2;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int ROW_W             = 12;
   localparam int RESET_WIDTH       = 640;
   localparam int RESET_HEIGHT      = 480;
   localparam int MIN_SIZE          = 3;
   localparam int SUM_W             = 12;
   localparam int QUEUE_DEPTH       = 3;
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic produce;
      logic last;
   } pos_flags_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] blurred;
      logic               last;
   } result_type;

endpackage

### design/gaussian_blur_3x3.sv
// Streaming 3x3 Gaussian blur over the valid region of a grayscale frame.
//
// Pixels enter in raster order on req_* (valid/ready); blurred pixels leave
// on rsp_* (valid/ready), one per input pixel at row >= 2 and column >= 2,
// with rsp_last_of_frame set on the last result of a frame.
// Frame size is set through csr_* (index 0: width, index 1: height); a write to
// either register restarts the frame position. Write only while idle.
// Throughput: one pixel per clock while req_ready is high. An accepted pixel
// is registered in the read stage, then in the result queue. The pace is set
// by the line store, read at accept and written back in the following cycle.
// A three-beat result queue absorbs receiver stalls; req_ready drops only
// when the queue and the read stage together hold three beats, so no result
// is lost while rsp_ready is low.
// Reset clears counters, window and queue and loads the 640 x 480 defaults.
// The line store is not cleared: entries feed only rows without results
// until written, so no clearing pass is needed.
module gaussian_blur_3x3 #(
   parameter int MAX_WIDTH = gb3_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gb3_pkg::PIXEL_W-1:0]       req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gb3_pkg::PIXEL_W-1:0]       rsp_blurred_pixel,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wen,
   input  logic [gb3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gb3_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gb3_pkg::*;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int RESET_EFF_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [COL_W-1:0]        last_col_ff, last_col_in;
   logic [ROW_W-1:0]        last_row_ff, last_row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    s1_valid_ff;
   pos_flags_type           s1_flags_ff;
   logic [PIXEL_W-1:0]      s1_pixel_ff;
   logic [COL_W-1:0]        s1_addr_ff;
   logic [WIDTH_REG_W-1:0]  width_raw;
   logic [HEIGHT_REG_W-1:0] height_raw;
   logic                    accept;
   logic                    csr_hit;
   pos_flags_type           flags;
   logic [2*PIXEL_W-1:0]    store_rd;
   logic                    push;
   result_type              push_data;
   result_type              rsp_data;
   logic [QUEUE_CNT_W-1:0]  q_count;
   logic [QUEUE_CNT_W:0]    in_flight;

   assign accept     = req_valid & req_ready;
   assign width_raw  = csr_wdata[WIDTH_REG_W-1:0];
   assign height_raw = csr_wdata[HEIGHT_REG_W-1:0];
   assign csr_hit    = csr_wen &&
                       (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   // saturate the frame size to the supported range
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (int'(width_raw) < MIN_SIZE) begin
                  last_col_in = COL_W'(MIN_SIZE - 1);
               end else if (int'(width_raw) > MAX_WIDTH) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(width_raw - WIDTH_REG_W'(1));
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (int'(height_raw) < MIN_SIZE) begin
                  last_row_in = ROW_W'(MIN_SIZE - 1);
               end else if (int'(height_raw) > HEIGHT_LIMIT) begin
                  last_row_in = ROW_W'(HEIGHT_LIMIT - 1);
               end else begin
                  last_row_in = ROW_W'(height_raw - HEIGHT_REG_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign flags.produce = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign flags.last    = (row_ff == last_row_ff) && (col_ff == last_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(RESET_EFF_W - 1);
         last_row_ff <= ROW_W'(RESET_HEIGHT - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
         s1_pixel_ff <= req_pixel_in;
         s1_addr_ff  <= col_ff;
      end
   end

   // read at accept, write back the shifted pair in the next cycle
   gb3_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (store_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({store_rd[PIXEL_W-1:0], s1_pixel_ff})
   );

   gb3_window u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_valid_ff),
      .flags  (s1_flags_ff),
      .pixel  (s1_pixel_ff),
      .upper  (store_rd[2*PIXEL_W-1:PIXEL_W]),
      .middle (store_rd[PIXEL_W-1:0]),
      .push   (push),
      .result (push_data)
   );

   gb3_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (q_count)
   );

   assign in_flight         = {1'b0, q_count} + (QUEUE_CNT_W+1)'(s1_valid_ff);
   assign req_ready         = (in_flight < (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
   assign rsp_blurred_pixel = rsp_data.blurred;
   assign rsp_last_of_frame = rsp_data.last;

endmodule

### design/gb3_line_store.sv
// Two-row line store: one memory of {upper, middle} pixel pairs with a registered read.
module gb3_line_store #(
   parameter int DEPTH  = gb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [2*gb3_pkg::PIXEL_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [2*gb3_pkg::PIXEL_W-1:0] wr_data
);
   import gb3_pkg::*;

   logic [2*PIXEL_W-1:0] mem [DEPTH];
   logic [2*PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gb3_window.sv
// 3x3 window columns and the 1-2-1 weighted sum with divide by sixteen.
module gb3_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  gb3_pkg::pos_flags_type        flags,
   input  logic [gb3_pkg::PIXEL_W-1:0]   pixel,
   input  logic [gb3_pkg::PIXEL_W-1:0]   upper,
   input  logic [gb3_pkg::PIXEL_W-1:0]   middle,
   output logic                          push,
   output gb3_pkg::result_type           result
);
   import gb3_pkg::*;

   logic [PIXEL_W-1:0] win_ff [6];
   logic [SUM_W-1:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (step) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper;
         win_ff[4] <= middle;
         win_ff[5] <= pixel;
      end
   end

   always_comb begin
      sum = SUM_W'(win_ff[0]) + (SUM_W'(win_ff[3]) << 1) + SUM_W'(upper)
          + (SUM_W'(win_ff[1]) << 1) + (SUM_W'(win_ff[4]) << 2) + (SUM_W'(middle) << 1)
          + SUM_W'(win_ff[2]) + (SUM_W'(win_ff[5]) << 1) + SUM_W'(pixel);
   end

   assign push           = step & flags.produce;
   assign result.blurred = sum[SUM_W-1:4];
   assign result.last    = flags.last;

endmodule

### design/gb3_rsp_queue.sv
// Three-entry result queue between the blur datapath and the response channel.
module gb3_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  gb3_pkg::result_type               push_data,
   input  logic                              pop_ready,
   output logic                              out_valid,
   output gb3_pkg::result_type               out_data,
   output logic [gb3_pkg::QUEUE_CNT_W-1:0]   count
);
   import gb3_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   result_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid & pop_ready;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/gb3_checker.sv
// Port-level checks of the blur block, bound to its top level.
module gb3_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [gb3_pkg::PIXEL_W-1:0]      rsp_blurred_pixel,
   input logic                             rsp_last_of_frame
);
   import gb3_pkg::*;

   // come out of reset empty and willing to take a beat
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty and ready after reset");

   // a new result needs an input beat accepted before it, via the read stage
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a matching input beat");

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_blurred_pixel) && $stable(rsp_last_of_frame)))
      else $error("result payload changed while stalled");

endmodule

bind gaussian_blur_3x3 gb3_checker u_gb3_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_blurred_pixel (rsp_blurred_pixel),
   .rsp_last_of_frame (rsp_last_of_frame)
);
